// ----- rtl/ipv4fh_pkg.sv -----
package ipv4fh_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned HDR_W   = 6;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PORT_W  = 16;
    localparam int unsigned HASH_W  = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = 7'd127;
    localparam logic [3:0]         IPV4_VERSION = 4'd4;
    localparam logic [7:0]         PROTO_TCP    = 8'd6;
    localparam logic [7:0]         PROTO_UDP    = 8'd17;
    localparam logic [COUNT_W-1:0] MIN_HDR_LEN  = 7'd20;
    localparam logic [COUNT_W-1:0] TCP_HDR_LEN  = 7'd20;
    localparam logic [COUNT_W-1:0] UDP_HDR_LEN  = 7'd8;

    // Byte offsets inside the IPv4 header
    localparam logic [COUNT_W-1:0] OFS_VER_IHL  = 7'd0;
    localparam logic [COUNT_W-1:0] OFS_PROTO    = 7'd9;
    localparam logic [COUNT_W-1:0] OFS_SRC_LO   = 7'd12;
    localparam logic [COUNT_W-1:0] OFS_SRC_HI   = 7'd15;
    localparam logic [COUNT_W-1:0] OFS_DST_LO   = 7'd16;
    localparam logic [COUNT_W-1:0] OFS_DST_HI   = 7'd19;
    localparam logic [COUNT_W-1:0] OFS_OPTIONS  = 7'd20;

    localparam logic [HASH_W-1:0]  HASH_SEED    = 32'h9e37_79b9;
    localparam logic [HASH_W-1:0]  HASH_MUL     = 32'h85eb_ca6b;
    localparam logic [HASH_W-1:0]  HASH_ONE     = 32'd1;

    typedef struct packed {
        logic              status;
        logic [7:0]        protocol;
        logic [ADDR_W-1:0] src_addr;
        logic [ADDR_W-1:0] dst_addr;
        logic [PORT_W-1:0] src_port;
        logic [PORT_W-1:0] dst_port;
    } t_flow;

endpackage

// ----- rtl/ipv4fh_parse.sv -----
module ipv4fh_parse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [ipv4fh_pkg::BYTE_W-1:0] i_data,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ipv4fh_pkg::t_flow             o_flow
);
    import ipv4fh_pkg::*;

    logic                r_valid;
    t_flow               r_flow;
    logic [COUNT_W-1:0]  r_count;
    logic [3:0]          r_ver;
    logic [3:0]          r_ihl;
    logic [7:0]          r_proto;
    logic [ADDR_W-1:0]   r_src;
    logic [ADDR_W-1:0]   r_dst;
    logic [PORT_W-1:0]   r_sport;
    logic [PORT_W-1:0]   r_dport;

    logic [3:0]          n_ver;
    logic [3:0]          n_ihl;
    logic [7:0]          n_proto;
    logic [ADDR_W-1:0]   n_src;
    logic [ADDR_W-1:0]   n_dst;
    logic [PORT_W-1:0]   n_sport;
    logic [PORT_W-1:0]   n_dport;
    logic [COUNT_W-1:0]  n_count;
    t_flow               n_flow;

    logic                accept;
    logic [COUNT_W-1:0]  hdr;
    logic                in_ports;
    logic                bad;
    logic                ports_ok;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_ver   = (r_count == OFS_VER_IHL) ? i_data[7:4] : r_ver;
        n_ihl   = (r_count == OFS_VER_IHL) ? i_data[3:0] : r_ihl;
        hdr     = {1'b0, n_ihl, 2'b00};
        n_proto = (r_count == OFS_PROTO) ? i_data : r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        n_sport = r_sport;
        n_dport = r_dport;
        if (r_count >= OFS_SRC_LO && r_count <= OFS_SRC_HI) begin
            n_src = {r_src[ADDR_W-BYTE_W-1:0], i_data};
        end
        if (r_count >= OFS_DST_LO && r_count <= OFS_DST_HI) begin
            n_dst = {r_dst[ADDR_W-BYTE_W-1:0], i_data};
        end
        in_ports = (r_count >= OFS_OPTIONS);
        if (in_ports && (r_count == hdr || r_count == hdr + 7'd1)) begin
            n_sport = {r_sport[PORT_W-BYTE_W-1:0], i_data};
        end
        if (in_ports && (r_count == hdr + 7'd2 || r_count == hdr + 7'd3)) begin
            n_dport = {r_dport[PORT_W-BYTE_W-1:0], i_data};
        end

        // Length including this byte, held at the top of the counter
        n_count = (r_count == COUNT_MAX) ? COUNT_MAX : r_count + 7'd1;

        bad = (n_count < MIN_HDR_LEN) || (n_ver != IPV4_VERSION) ||
              (hdr < MIN_HDR_LEN) || (hdr > n_count);
        ports_ok = ((n_proto == PROTO_TCP) && (n_count >= hdr + TCP_HDR_LEN)) ||
                   ((n_proto == PROTO_UDP) && (n_count >= hdr + UDP_HDR_LEN));

        n_flow = '0;
        if (bad) begin
            n_flow.status = 1'b1;
        end else begin
            n_flow.protocol = n_proto;
            n_flow.src_addr = n_src;
            n_flow.dst_addr = n_dst;
            n_flow.src_port = ports_ok ? n_sport : '0;
            n_flow.dst_port = ports_ok ? n_dport : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= i_last ? '0 : n_count;
            end
            if (o_ready) begin
                r_valid <= accept && i_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ver   <= n_ver;
            r_ihl   <= n_ihl;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
            r_sport <= n_sport;
            r_dport <= n_dport;
        end
        if (accept && i_last && o_ready) begin
            r_flow <= n_flow;
        end
    end

    assign o_valid = r_valid;
    assign o_flow  = r_flow;

endmodule

// ----- rtl/ipv4fh_hash.sv -----
module ipv4fh_hash (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  ipv4fh_pkg::t_flow             i_flow,
    output logic                          o_valid,
    input  logic                          i_ready,
    output ipv4fh_pkg::t_flow             o_flow,
    output logic [ipv4fh_pkg::HASH_W-1:0] o_hash
);
    import ipv4fh_pkg::*;

    logic               r_b_valid;
    logic               r_c_valid;
    logic               r_d_valid;
    t_flow              r_b_flow;
    t_flow              r_c_flow;
    t_flow              r_d_flow;
    logic [HASH_W-1:0]  r_b_h;
    logic [HASH_W-1:0]  r_c_h;
    logic [HASH_W-1:0]  r_c_prod;
    logic [HASH_W-1:0]  r_d_hash;

    logic               ready_b;
    logic               ready_c;
    logic               ready_d;
    logic [HASH_W-1:0]  s_word;
    logic [HASH_W-1:0]  d_word;
    logic [HASH_W-1:0]  n_b_h;
    logic [HASH_W-1:0]  rot_h;
    logic [HASH_W-1:0]  n_c_prod;
    logic [HASH_W-1:0]  mix;
    logic [HASH_W-1:0]  fold;
    logic [HASH_W-1:0]  n_d_hash;

    assign ready_d = !r_d_valid || i_ready;
    assign ready_c = !r_c_valid || ready_d;
    assign ready_b = !r_b_valid || ready_c;
    assign o_ready = ready_b;

    // Addresses enter the hash byte-swapped, first header byte in bits 7:0
    assign s_word = {i_flow.src_addr[7:0], i_flow.src_addr[15:8],
                     i_flow.src_addr[23:16], i_flow.src_addr[31:24]};
    assign d_word = {i_flow.dst_addr[7:0], i_flow.dst_addr[15:8],
                     i_flow.dst_addr[23:16], i_flow.dst_addr[31:24]};
    assign n_b_h  = HASH_SEED ^ (s_word + {d_word[15:0], d_word[31:16]}) ^
                    {i_flow.src_port, i_flow.dst_port} ^ {i_flow.protocol, 24'd0};

    assign rot_h    = {r_b_h[18:0], r_b_h[31:19]};
    assign n_c_prod = rot_h * HASH_MUL;

    always_comb begin
        mix  = r_c_h ^ r_c_prod;
        fold = mix ^ {16'd0, mix[31:16]};
        if (r_c_flow.status) begin
            n_d_hash = '0;
        end else if (fold == '0) begin
            n_d_hash = HASH_ONE;
        end else begin
            n_d_hash = fold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (ready_b) begin
                r_b_valid <= i_valid;
            end
            if (ready_c) begin
                r_c_valid <= r_b_valid;
            end
            if (ready_d) begin
                r_d_valid <= r_c_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && i_valid) begin
            r_b_flow <= i_flow;
            r_b_h    <= n_b_h;
        end
        if (ready_c && r_b_valid) begin
            r_c_flow <= r_b_flow;
            r_c_h    <= r_b_h;
            r_c_prod <= n_c_prod;
        end
        if (ready_d && r_c_valid) begin
            r_d_flow <= r_c_flow;
            r_d_hash <= n_d_hash;
        end
    end

    assign o_valid = r_d_valid;
    assign o_flow  = r_d_flow;
    assign o_hash  = r_d_hash;

endmodule

// ----- rtl/ipv4_five_tuple_flow_hash_top.sv -----
// IPv4 five-tuple extractor with flow hash.
//
// Input channel: one packet byte per item on i_s_axis_tdata, starting at the
// IPv4 header, with i_s_axis_tlast high on the final byte of the packet.
// Output channel: one item per packet. o_m_axis_tuser is the status (0 parsed,
// 1 rejected); o_m_axis_tdata holds protocol, addresses, ports and flow hash.
// A rejected packet (short, not version 4, bad header length) gives all-zero
// data with status 1. Ports are zero unless a full TCP or UDP header fits.
//
// Throughput: one byte per cycle while the output does not stall; packets of
// any length, down to one byte, follow each other with no gap. The result
// reaches the master side through the parse register, then the add stage and
// multiply stage into the output register.
//
// Reset clears the byte counter and all stage valid bits; a packet in flight
// is dropped. When the receiver holds i_m_axis_tready low, the output item is
// held and the stages fill up behind it; once all are full, o_s_axis_tready
// falls and the input stalls until the output drains.
module ipv4_five_tuple_flow_hash_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tlast,   // last_byte
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [7:0] protocol, [39:8] src_addr, [71:40] dst_addr, [87:72] src_port,
    // [103:88] dst_port, [135:104] flow_hash
    output logic [135:0] o_m_axis_tdata,
    output logic         o_m_axis_tuser    // [0] status
);
    import ipv4fh_pkg::*;

    logic              parse_valid;
    logic              hash_ready;
    t_flow             parse_flow;
    t_flow             out_flow;
    logic [HASH_W-1:0] out_hash;

    // Capture header fields byte by byte and judge the packet on its last byte
    ipv4fh_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_valid (parse_valid),
        .i_ready (hash_ready),
        .o_flow  (parse_flow)
    );

    // Mix the tuple into the flow hash; the last stage is the output register
    ipv4fh_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (parse_valid),
        .o_ready (hash_ready),
        .i_flow  (parse_flow),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_flow  (out_flow),
        .o_hash  (out_hash)
    );

    // Pack the result, first field in the lowest bits
    assign o_m_axis_tdata = {out_hash, out_flow.dst_port, out_flow.src_port,
                             out_flow.dst_addr, out_flow.src_addr, out_flow.protocol};
    assign o_m_axis_tuser = out_flow.status;

endmodule
